// ===== src/fba_pkg.sv =====
package fba_pkg;

    localparam int MAX_FRAMES    = 4096;
    localparam int WORD_BITS     = 32;
    localparam int WORD_COUNT    = MAX_FRAMES / WORD_BITS;
    localparam int FRAMES_PER_MB = 256;

    localparam int MB_W      = 5;
    localparam int FRAME_W   = 12;
    localparam int COUNT_W   = 13;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int ADDR_W    = $clog2(WORD_COUNT);
    localparam int WORDS_W   = $clog2(WORD_COUNT + 1);
    localparam int FPM_W     = $clog2(FRAMES_PER_MB);
    localparam int CALC_W    = MB_W + FPM_W;

    localparam int S_TDATA_W = ((FRAME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((FRAME_W + COUNT_W + 7) / 8) * 8;

    localparam logic [MB_W-1:0] MB_RESET = MB_W'(16);

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_OUT_OF_FRAMES = 2'd1,
        ST_OUT_OF_RANGE  = 2'd2,
        ST_NOT_ALLOCATED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [FRAME_W-1:0] granted;
        status_t            status;
        logic [COUNT_W-1:0] in_use;
    } rsp_t;

    function automatic logic [WORDS_W-1:0] words_in_use(input logic [MB_W-1:0] mb);
        logic [CALC_W-1:0] frames;
        frames = CALC_W'(mb) << FPM_W;
        if (frames > CALC_W'(MAX_FRAMES)) begin
            frames = CALC_W'(MAX_FRAMES);
        end
        return WORDS_W'(frames >> BIT_W);
    endfunction

    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== src/frame_bitmap_allocator.sv =====
// First-fit physical frame allocator: one bit per 4 KiB frame, held in a 128 x 32
// bitmap RAM. Items are handled one at a time. An allocate reads bitmap words in turn,
// from word 0, through the RAM read port (one word per cycle) until a free bit is
// found or the words in use run out. A free makes one read of the frame's word and,
// if its bit is set, one write. A free of a frame out of range, or an allocate with
// no words in use, goes straight to the result without touching the bitmap.
// The bitmap is free right after reset (per-word valid bits, no clearing pass).
// Write memory_megabytes on the cfg channel only while no item is in flight; it
// sets 256 frames per MB, capped at 4096.
module frame_bitmap_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fba_pkg::MB_W-1:0]      cfg_data,   // memory_megabytes
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fba_pkg::S_TDATA_W-1:0] s_tdata,    // frame_number
    input  logic                          s_tuser,    // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fba_pkg::M_TDATA_W-1:0] m_tdata,    // granted_frame, frames_in_use
    output logic [1:0]                    m_tuser     // status
);
    import fba_pkg::*;

    logic [MB_W-1:0]      mb_reg;
    logic [WORDS_W-1:0]   words;
    logic                 rsp_valid;
    logic                 rsp_ready;
    rsp_t                 rsp;
    logic                 m_tvalid_reg;
    rsp_t                 out_reg;

    assign cfg_ready = 1'b1;
    assign words     = words_in_use(mb_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mb_reg <= MB_RESET;
        end else if (cfg_valid && cfg_ready) begin
            mb_reg <= cfg_data;
        end
    end

    fba_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_type  (req_t'(s_tuser)),
        .req_frame (s_tdata[FRAME_W-1:0]),
        .words     (words),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    assign rsp_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (rsp_ready) begin
            m_tvalid_reg <= rsp_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_ready && rsp_valid) begin
            out_reg <= rsp;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({out_reg.in_use, out_reg.granted});
    assign m_tuser  = out_reg.status;

endmodule

// ===== src/fba_ram.sv =====
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/fba_engine.sv =====
module fba_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  fba_pkg::req_t               req_type,
    input  logic [fba_pkg::FRAME_W-1:0] req_frame,
    input  logic [fba_pkg::WORDS_W-1:0] words,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output fba_pkg::rsp_t               rsp
);
    import fba_pkg::*;

    state_t               state_reg, state_next;
    req_t                 type_reg, type_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [FRAME_W-1:0]   granted_reg, granted_next;
    status_t              status_reg, status_next;
    logic [WORD_COUNT-1:0] valid_reg;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] word_eff;
    logic [BIT_W-1:0]     zero_bit;
    logic [BIT_W-1:0]     free_bit;
    logic [ADDR_W-1:0]    req_idx;

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign word_eff = valid_reg[idx_reg] ? ram_rdata : '0;
    assign zero_bit = lowest_zero(word_eff);
    assign free_bit = frame_reg[BIT_W-1:0];
    assign req_idx  = req_frame[FRAME_W-1:BIT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (ram_we) begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        type_reg    <= type_next;
        frame_reg   <= frame_next;
        idx_reg     <= idx_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    always_comb begin
        state_next   = state_reg;
        type_next    = type_reg;
        frame_next   = frame_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        granted_next = granted_reg;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_wdata    = word_eff;
        ram_raddr    = idx_reg;
        req_ready    = 1'b0;
        rsp_valid    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                ram_raddr = (req_type == REQ_FREE) ? req_idx : '0;
                if (req_valid) begin
                    type_next  = req_type;
                    frame_next = req_frame;
                    idx_next   = ram_raddr;
                    if (req_type == REQ_ALLOC) begin
                        if (words == '0) begin
                            granted_next = '0;
                            status_next  = ST_OUT_OF_FRAMES;
                            state_next   = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else if (WORDS_W'(req_idx) >= words) begin
                        granted_next = req_frame;
                        status_next  = ST_OUT_OF_RANGE;
                        state_next   = S_DONE;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_SCAN: begin
                if (word_eff != '1) begin
                    ram_we       = 1'b1;
                    ram_wdata    = word_eff | (WORD_BITS'(1) << zero_bit);
                    count_next   = count_reg + 1'b1;
                    granted_next = {idx_reg, zero_bit};
                    status_next  = ST_OK;
                    state_next   = S_DONE;
                end else if (WORDS_W'(idx_reg) + 1'b1 == words) begin
                    granted_next = '0;
                    status_next  = ST_OUT_OF_FRAMES;
                    state_next   = S_DONE;
                end else begin
                    idx_next  = idx_reg + 1'b1;
                    ram_raddr = idx_reg + 1'b1;
                end
            end
            S_CHECK: begin
                granted_next = frame_reg;
                if (!word_eff[free_bit]) begin
                    status_next = ST_NOT_ALLOCATED;
                end else begin
                    ram_we      = 1'b1;
                    ram_wdata   = word_eff & ~(WORD_BITS'(1) << free_bit);
                    count_next  = count_reg - 1'b1;
                    status_next = ST_OK;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                rsp_valid = 1'b1;
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.granted = granted_reg;
    assign rsp.status  = status_reg;
    assign rsp.in_use  = count_reg;

    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_SCAN || state_reg == S_CHECK))
        else $error("bitmap write outside scan or check");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_FRAMES))
        else $error("allocated count beyond frame total");

    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && state_next == S_SCAN) |=> idx_reg == $past(idx_reg) + 1'b1)
        else $error("scan skipped a word");

    a_alloc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && ram_we) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("allocate did not bump count");

    a_alloc_type: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> type_reg == REQ_ALLOC)
        else $error("scan on a free request");

endmodule
